// File: rtl/stereo_peak_meter_bargraph_assert.svh
// Assertion macros shared by the stereo peak meter RTL.
`ifndef STEREO_PEAK_METER_BARGRAPH_ASSERT_SVH
`define STEREO_PEAK_METER_BARGRAPH_ASSERT_SVH

// Same-cycle implication, clocked by i_clk and disabled during reset.
`define SPMB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked by i_clk and disabled during reset.
`define SPMB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/spmb_pkg.sv
// Types, constants and per-channel update functions of the stereo peak meter.
package spmb_pkg;

    localparam int SEGMENTS   = 24;
    localparam int LEVEL_BITS = 16;
    localparam int SEG_W      = $clog2(SEGMENTS + 1);
    localparam int DECAY_W    = 16;
    localparam int HOLD_W     = 8;
    localparam int PROD_W     = LEVEL_BITS + DECAY_W;
    localparam int CFG_IDX_W  = 2;

    typedef logic [LEVEL_BITS-1:0] t_level;
    typedef logic [SEG_W-1:0]      t_seg;

    localparam logic [DECAY_W-1:0] PEAK_DECAY    = 16'd62259;
    localparam t_level             PEAK_SHOW_MIN = LEVEL_BITS'(17);
    localparam t_level             UNITY_LEVEL   = LEVEL_BITS'(16384);

    localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd58982;
    localparam logic [HOLD_W-1:0]  HOLD_RESET   = 8'd45;
    localparam logic               STEREO_RESET = 1'b0;

    localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE  = 2'd2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam t_level SEG_THR [SEGMENTS] = '{
        LEVEL_BITS'(23),    LEVEL_BITS'(31),    LEVEL_BITS'(43),    LEVEL_BITS'(59),
        LEVEL_BITS'(80),    LEVEL_BITS'(110),   LEVEL_BITS'(151),   LEVEL_BITS'(207),
        LEVEL_BITS'(284),   LEVEL_BITS'(389),   LEVEL_BITS'(534),   LEVEL_BITS'(732),
        LEVEL_BITS'(1005),  LEVEL_BITS'(1379),  LEVEL_BITS'(1892),  LEVEL_BITS'(2597),
        LEVEL_BITS'(3564),  LEVEL_BITS'(4892),  LEVEL_BITS'(6714),  LEVEL_BITS'(9214),
        LEVEL_BITS'(12646), LEVEL_BITS'(17355), LEVEL_BITS'(23819), LEVEL_BITS'(32691)
    };

    typedef struct packed {
        t_level              shown;
        t_level              peak;
        logic [HOLD_W-1:0]   count;
    } t_chan;

    typedef struct packed {
        t_level shown;
        t_level peak;
    } t_snap;

    typedef struct packed {
        logic clip;
        logic shown;
        t_seg pos;
        t_seg bar;
    } t_res;

    function automatic t_seg seg_count(t_level lvl);
        t_seg n;
        n = '0;
        for (int k = 0; k < SEGMENTS; k++) begin
            if (lvl >= SEG_THR[k]) begin
                n = n + 1'b1;
            end
        end
        return n;
    endfunction

    function automatic t_chan tick_chan(t_chan cur, t_level newlvl,
                                        logic [DECAY_W-1:0] df, logic [HOLD_W-1:0] hold);
        logic [PROD_W-1:0] dprod;
        logic [PROD_W-1:0] pprod;
        t_level            decayed;
        t_level            disp;
        t_chan             nxt;
        dprod   = PROD_W'(cur.shown) * PROD_W'(df);
        pprod   = PROD_W'(cur.peak) * PROD_W'(PEAK_DECAY);
        decayed = dprod[PROD_W-1:DECAY_W];
        disp    = (newlvl > decayed) ? newlvl : decayed;
        nxt       = cur;
        nxt.shown = disp;
        if (disp > cur.peak) begin
            nxt.peak  = disp;
            nxt.count = hold;
        end else if (cur.count != '0) begin
            nxt.count = cur.count - 1'b1;
        end else begin
            nxt.peak = pprod[PROD_W-1:DECAY_W];
        end
        return nxt;
    endfunction

    function automatic t_res emit_chan(t_snap s);
        t_res r;
        r.bar   = seg_count(s.shown);
        r.pos   = seg_count(s.peak);
        r.shown = (s.peak >= PEAK_SHOW_MIN) && (r.pos < SEG_W'(SEGMENTS));
        r.clip  = (s.peak > UNITY_LEVEL);
        return r;
    endfunction

endpackage

// File: rtl/stereo_peak_meter_bargraph.sv
// Stereo peak meter with hold and decay, reduced to segment bargraph results.
//
//  channel   | dir | tdata (low bit up)                 | tuser
//  s_axis    | in  | level_left, level_right            | opcode
//  m_axis    | out | bar/peak_pos/peak_shown/clip L, R  | -
//  cfg       | in  | write enable, index, data          | -
//
// One item per clock sustained while the output is not stalled; an item passes stages A, B and C in turn.
// The rate is set by the display and peak update, two 16x16 multiplies per channel and cycle.
// Synchronous active-low reset clears the meter state and loads the register defaults.
// A stalled output holds its item, and the two upstream stages keep filling behind it.
`include "stereo_peak_meter_bargraph_assert.svh"

module stereo_peak_meter_bargraph (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // level_left, level_right
    input  logic        i_s_axis_tuser,   // opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // bar_l, pos_l, shown_l, clip_l, bar_r, pos_r, shown_r, clip_r
    input  logic        i_cfg_we,
    input  logic [spmb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [spmb_pkg::DECAY_W-1:0]   i_cfg_data
);

    logic [spmb_pkg::DECAY_W-1:0] r_decay;
    logic [spmb_pkg::HOLD_W-1:0]  r_hold;
    logic                         r_stereo;

    logic            r_a_valid;
    logic            r_a_op;
    spmb_pkg::t_level r_a_left;
    spmb_pkg::t_level r_a_right;

    logic            r_b_valid;
    spmb_pkg::t_snap r_b_left;
    spmb_pkg::t_snap r_b_right;

    logic            r_c_valid;
    logic [23:0]     r_c_data;

    spmb_pkg::t_chan r_st_left;
    spmb_pkg::t_chan r_st_right;
    spmb_pkg::t_chan n_st_left;
    spmb_pkg::t_chan n_st_right;

    spmb_pkg::t_res  res_left;
    spmb_pkg::t_res  res_right;

    logic c_ld;
    logic b_ld;
    logic a_ld;

    assign c_ld = r_b_valid && (!r_c_valid || i_m_axis_tready);
    assign b_ld = r_a_valid && (!r_b_valid || c_ld);
    assign o_s_axis_tready = !r_a_valid || b_ld;
    assign a_ld = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_c_valid;
    assign o_m_axis_tdata  = r_c_data;

    always_comb begin
        n_st_left  = r_st_left;
        n_st_right = r_st_right;
        if (r_a_op == spmb_pkg::OP_CLEAR) begin
            n_st_left.peak   = '0;
            n_st_left.count  = '0;
            n_st_right.peak  = '0;
            n_st_right.count = '0;
        end else begin
            n_st_left  = spmb_pkg::tick_chan(r_st_left, r_a_left, r_decay, r_hold);
            n_st_right = spmb_pkg::tick_chan(r_st_right, r_a_right, r_decay, r_hold);
        end
    end

    always_comb begin
        res_left  = spmb_pkg::emit_chan(r_b_left);
        res_right = spmb_pkg::emit_chan(r_b_right);
        if (!r_stereo) begin
            res_right = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay    <= spmb_pkg::DECAY_RESET;
            r_hold     <= spmb_pkg::HOLD_RESET;
            r_stereo   <= spmb_pkg::STEREO_RESET;
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_c_valid  <= 1'b0;
            r_st_left  <= '0;
            r_st_right <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    spmb_pkg::REG_DECAY_FACTOR: r_decay  <= i_cfg_data;
                    spmb_pkg::REG_HOLD_TICKS:   r_hold   <= i_cfg_data[spmb_pkg::HOLD_W-1:0];
                    spmb_pkg::REG_STEREO_MODE:  r_stereo <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (o_s_axis_tready) begin
                r_a_valid <= i_s_axis_tvalid;
            end
            if (b_ld) begin
                r_st_left  <= n_st_left;
                r_st_right <= n_st_right;
            end
            if (!r_b_valid || c_ld) begin
                r_b_valid <= b_ld;
            end
            if (!r_c_valid || i_m_axis_tready) begin
                r_c_valid <= c_ld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ld) begin
            r_a_op    <= i_s_axis_tuser;
            r_a_left  <= i_s_axis_tdata[15:0];
            r_a_right <= i_s_axis_tdata[31:16];
        end
        if (b_ld) begin
            r_b_left  <= '{shown: n_st_left.shown, peak: n_st_left.peak};
            r_b_right <= '{shown: n_st_right.shown, peak: n_st_right.peak};
        end
        if (c_ld) begin
            r_c_data <= {res_right, res_left};
        end
    end

    `SPMB_ASSERT_NXT(a_clear_zeroes_peaks, b_ld && (r_a_op == spmb_pkg::OP_CLEAR), (r_st_left.peak == '0) && (r_st_right.peak == '0) && (r_st_left.count == '0), "clear left a held peak")
    `SPMB_ASSERT_NXT(a_shown_follows_level, b_ld && (r_a_op == spmb_pkg::OP_TICK), (r_st_left.shown >= $past(r_a_left)) && (r_st_right.shown >= $past(r_a_right)), "display fell below the new level")
    `SPMB_ASSERT_NXT(a_peak_covers_shown, b_ld, (r_st_left.peak >= r_st_left.shown) || ($past(r_a_op) == spmb_pkg::OP_CLEAR) || ($past(r_st_left.count) == '0), "held peak below display while holding")
    `SPMB_ASSERT_IMP(a_mono_right_zero, r_c_valid && !r_stereo, r_c_data[23:12] == '0, "right channel result not zero in mono")
    `SPMB_ASSERT_IMP(a_shown_below_top, r_c_valid && r_c_data[10], r_c_data[9:5] < spmb_pkg::SEG_W'(spmb_pkg::SEGMENTS), "peak shown at top index")

endmodule
